>>> sv/dqmm_pkg.sv
package dqmm_pkg;

    localparam int DQMM_DEPTH      = 16;
    localparam int DQMM_DATA_WIDTH = 32;
    localparam int MODE_W          = 3;

    // command codes on the mode port
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_MAX        = 3'd4,
        MODE_MIN        = 3'd5
    } mode_t;

    // per-cycle operation broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_BACK,
        CELL_PUSH_FRONT,
        CELL_POP_FRONT,
        CELL_ROTATE
    } cell_op_t;

endpackage

>>> sv/dqmm_cell.sv
module dqmm_cell
    import dqmm_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = DQMM_DATA_WIDTH,
    parameter int COUNT_W    = 5
)
(
    input  logic                  clk,
    input  cell_op_t              op,
    input  logic [COUNT_W-1:0]    count,
    input  logic [DATA_WIDTH-1:0] push_data,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [DATA_WIDTH-1:0] head_data,
    output logic [DATA_WIDTH-1:0] data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  is_tail_slot;
    logic                  is_last;

    // first free slot and last held slot, from the fill count
    assign is_tail_slot = (count == COUNT_W'(IDX));
    assign is_last      = (count == COUNT_W'(IDX + 1));

    always_comb
    begin
        data_next = data_reg;
        unique case (op)
            CELL_PUSH_BACK:
            begin
                if (is_tail_slot)
                begin
                    data_next = push_data;
                end
            end
            CELL_PUSH_FRONT: data_next = left_data;
            CELL_POP_FRONT:  data_next = right_data;
            CELL_ROTATE:     data_next = is_last ? head_data : right_data;
            default:         data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

>>> sv/double_ended_queue_minmax_top.sv
// channel   direction  handshake                 fields
// request   in         start & !busy             mode, value
// result    out        done (one-cycle strobe)   front_value, back_value, entry_count,
//                                                extreme_value, empty_error, full_error
//
// push and pop requests leave busy low: the result strobes in the cycle after the
// request, so a new request can be taken on every edge.
// a max or min query on a non-empty queue rotates the held entries once around the
// cell row past one comparator with busy high; the result strobes once the rotation is done.
// rst_n clears the fill count and control; the entry cells hold no reset value.
// the receiver cannot stall: each result is on the ports for exactly one cycle.
module double_ended_queue_minmax_top
    import dqmm_pkg::*;
#(
    parameter int DEPTH      = DQMM_DEPTH,
    parameter int DATA_WIDTH = DQMM_DATA_WIDTH,
    parameter int COUNT_W    = $clog2(DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [MODE_W-1:0]     mode,
    input  logic [DATA_WIDTH-1:0] value,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] front_value,
    output logic [DATA_WIDTH-1:0] back_value,
    output logic [COUNT_W-1:0]    entry_count,
    output logic [DATA_WIDTH-1:0] extreme_value,
    output logic                  empty_error,
    output logic                  full_error
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                state_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    scan_cnt_reg;
    logic                  scan_first_reg;
    logic                  scan_max_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic                  done_reg;
    logic [DATA_WIDTH-1:0] extreme_reg;
    logic                  empty_err_reg;
    logic                  full_err_reg;

    cell_op_t              op;
    logic                  accept;
    logic                  is_empty;
    logic                  is_full;
    logic                  better;
    logic [DATA_WIDTH-1:0] acc_next;
    logic [DATA_WIDTH-1:0] back_sel;

    // cell row: cell 0 holds the front entry, cell count-1 the back entry
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    assign busy     = (state_reg == ST_SCAN);
    assign accept   = start && !busy;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == COUNT_W'(DEPTH));

    // operation handed to every cell this cycle
    always_comb
    begin
        op = CELL_HOLD;
        if (busy)
        begin
            op = CELL_ROTATE;
        end
        else if (accept)
        begin
            unique case (mode)
                MODE_PUSH_BACK:  op = is_full  ? CELL_HOLD : CELL_PUSH_BACK;
                MODE_PUSH_FRONT: op = is_full  ? CELL_HOLD : CELL_PUSH_FRONT;
                MODE_POP_FRONT:  op = is_empty ? CELL_HOLD : CELL_POP_FRONT;
                default:         op = CELL_HOLD;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_w;
            logic [DATA_WIDTH-1:0] right_w;

            // a push at the front enters cell 0 from the request word
            if (gi == 0)
            begin : g_first
                assign left_w = value;
            end
            else
            begin : g_mid
                assign left_w = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_end
                assign right_w = cell_data[gi];
            end
            else
            begin : g_inner
                assign right_w = cell_data[gi+1];
            end

            dqmm_cell #(
                .IDX        (gi),
                .DATA_WIDTH (DATA_WIDTH),
                .COUNT_W    (COUNT_W)
            ) u_cell (
                .clk        (clk),
                .op         (op),
                .count      (count_reg),
                .push_data  (value),
                .left_data  (left_w),
                .right_data (right_w),
                .head_data  (cell_data[0]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    // back entry: and-or over the cells, only the last held cell passes
    always_comb
    begin
        back_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (count_reg == COUNT_W'(i + 1))
            begin
                back_sel = back_sel | cell_data[i];
            end
        end
    end

    // scan comparator: the front cell streams every held entry past it
    assign better   = scan_max_reg ? ($signed(cell_data[0]) > $signed(acc_reg))
                                   : ($signed(cell_data[0]) < $signed(acc_reg));
    assign acc_next = (scan_first_reg || better) ? cell_data[0] : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            scan_cnt_reg   <= '0;
            scan_first_reg <= 1'b0;
            scan_max_reg   <= 1'b0;
            acc_reg        <= '0;
            done_reg       <= 1'b0;
            extreme_reg    <= '0;
            empty_err_reg  <= 1'b0;
            full_err_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        empty_err_reg <= 1'b0;
                        full_err_reg  <= 1'b0;
                        extreme_reg   <= '0;
                        done_reg      <= 1'b1;
                        unique case (mode)
                            MODE_PUSH_BACK, MODE_PUSH_FRONT:
                            begin
                                if (is_full)
                                begin
                                    full_err_reg <= 1'b1;
                                end
                                else
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            MODE_POP_BACK, MODE_POP_FRONT:
                            begin
                                if (is_empty)
                                begin
                                    empty_err_reg <= 1'b1;
                                end
                                else
                                begin
                                    count_reg <= count_reg - 1'b1;
                                end
                            end
                            MODE_MAX, MODE_MIN:
                            begin
                                if (is_empty)
                                begin
                                    empty_err_reg <= 1'b1;
                                    extreme_reg   <= '1;
                                end
                                else
                                begin
                                    // result comes at the end of the rotation
                                    done_reg       <= 1'b0;
                                    state_reg      <= ST_SCAN;
                                    scan_cnt_reg   <= count_reg;
                                    scan_first_reg <= 1'b1;
                                    scan_max_reg   <= (mode == MODE_MAX);
                                end
                            end
                            default:
                            begin
                                // unused codes just report the queue
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    acc_reg        <= acc_next;
                    scan_first_reg <= 1'b0;
                    scan_cnt_reg   <= scan_cnt_reg - 1'b1;
                    // once every held entry has rotated past the front, the row is back in order
                    if (scan_cnt_reg == COUNT_W'(1))
                    begin
                        state_reg   <= ST_IDLE;
                        extreme_reg <= acc_next;
                        done_reg    <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign entry_count   = count_reg;
    assign front_value   = is_empty ? '1 : cell_data[0];
    assign back_value    = is_empty ? '1 : back_sel;
    assign extreme_value = extreme_reg;
    assign empty_error   = empty_err_reg;
    assign full_error    = full_err_reg;

endmodule
